[hdl/cdsr_pkg.sv]
// cdsr_pkg: shared constants, types and time arithmetic for the shock recovery monitor
package cdsr_pkg;

  localparam logic [7:0] TIMER_LOAD_SINGLE = 8'd40;
  localparam logic [7:0] TIMER_LOAD_DOUBLE = 8'd20;

  localparam logic [1:0] OP_POLL    = 2'd0;
  localparam logic [1:0] OP_ENABLE  = 2'd1;
  localparam logic [1:0] OP_DISABLE = 2'd2;

  localparam logic [1:0] KIND_OTHER   = 2'd0;
  localparam logic [1:0] KIND_ABS     = 2'd1;
  localparam logic [1:0] KIND_LEAD_IN = 2'd2;

  localparam logic [1:0] JST_READY = 2'd0;
  localparam logic [1:0] JST_ERROR = 2'd1;
  localparam logic [1:0] JST_BUSY  = 2'd2;

  localparam logic [6:0] WIN_LOW_FRM   = 7'h0F;
  localparam logic [6:0] JUMP_AHEAD_FRM = 7'h28;
  localparam logic       WIN_HIGH_SEC  = 1'b1;

  typedef struct packed {
    logic [6:0] min;
    logic [5:0] sec;
    logic [6:0] frm;
  } cdsr_time_t;

  typedef struct packed {
    logic [1:0] op;
    logic       timer_expired;
    logic [1:0] subcode_kind;
    cdsr_time_t now;
    logic [1:0] jump_status;
    cdsr_time_t target;
  } cdsr_item_t;

  typedef struct packed {
    logic       mute_set;
    logic       mute_clear;
    logic       jump_request;
    cdsr_time_t jump;
    logic       timer_reload;
    logic [7:0] reload_value;
    logic       active;
    logic       repairing;
  } cdsr_result_t;

  // add seconds and frames with one carry per stage, then mask to field widths
  function automatic cdsr_time_t msf_add(cdsr_time_t a, logic sec_add, logic [6:0] frm_add);
    logic [7:0] f;
    logic [6:0] s;
    logic [7:0] m;
    logic       c_f;
    logic       c_s;
    cdsr_time_t r;
    f   = {1'b0, a.frm} + {1'b0, frm_add};
    c_f = (f >= 8'd75);
    if (c_f) f = f - 8'd75;
    s   = {1'b0, a.sec} + {6'b0, sec_add} + {6'b0, c_f};
    c_s = (s >= 7'd60);
    if (c_s) s = s - 7'd60;
    m   = {1'b0, a.min} + {7'b0, c_s};
    if (m >= 8'd100) m = m - 8'd100;
    r.min = m[6:0];
    r.sec = s[5:0];
    r.frm = f[6:0];
    return r;
  endfunction

endpackage

[hdl/cdsr_if.sv]
// cdsr_in_if and cdsr_out_if: valid/ready channels for requests and results
interface cdsr_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic       timer_expired;
  logic [1:0] subcode_kind;
  logic [6:0] now_min;
  logic [5:0] now_sec;
  logic [6:0] now_frm;
  logic [1:0] jump_status;
  logic [6:0] target_min;
  logic [5:0] target_sec;
  logic [6:0] target_frm;

  modport source (output valid, op, timer_expired, subcode_kind, now_min, now_sec, now_frm,
                  jump_status, target_min, target_sec, target_frm, input ready);
  modport sink   (input valid, op, timer_expired, subcode_kind, now_min, now_sec, now_frm,
                  jump_status, target_min, target_sec, target_frm, output ready);
endinterface

interface cdsr_out_if;
  logic       valid;
  logic       ready;
  logic       mute_set;
  logic       mute_clear;
  logic       jump_request;
  logic [6:0] jump_min;
  logic [5:0] jump_sec;
  logic [6:0] jump_frm;
  logic       timer_reload;
  logic [7:0] reload_value;
  logic       active;
  logic       repairing;

  modport source (output valid, mute_set, mute_clear, jump_request, jump_min, jump_sec,
                  jump_frm, timer_reload, reload_value, active, repairing, input ready);
  modport sink   (input valid, mute_set, mute_clear, jump_request, jump_min, jump_sec,
                  jump_frm, timer_reload, reload_value, active, repairing, output ready);
endinterface

[hdl/cd_shock_recovery_monitor.sv]
// cd_shock_recovery_monitor: subcode time continuity monitor with mute and jump repair
//
// Requests arrive on in_ch (valid/ready): an op (poll, enable, disable) together with
// the progress timer flag, subcode kind, current absolute time, the outcome of the
// jump request of this step and the play target. Every request gives exactly one
// result on out_ch: mute switching, jump request and target, timer reload and load
// value, and the monitor and repair flags after the step.
// cfg_we/cfg_wdata write single_speed (reset 1), which picks the timer load value;
// write it only while no request is in flight.
// A request is first captured in the input register, then the time adders, window
// compares and state update feed the result register.
// Throughput is one request per cycle while the receiver takes results; the
// input register is refilled in the same cycle that its request moves to the
// result register.
// When the receiver stalls, the result holds, the input register keeps the next
// request and in_ch.ready drops once both are full.
// Reset (rst_n low, synchronous) clears monitor, repair, reference time and both
// valid flags, and sets single speed.
module cd_shock_recovery_monitor
  import cdsr_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  cdsr_in_if.sink      in_ch,
  cdsr_out_if.source   out_ch,
  input  logic         cfg_we,
  input  logic         cfg_wdata
);

  logic         single_speed_r;
  logic         monitor_r, monitor_nxt;
  logic         repair_r, repair_nxt;
  cdsr_time_t   ref_r, ref_nxt;

  logic         s1_valid_r;
  cdsr_item_t   s1_r;
  logic         out_valid_r;
  cdsr_result_t out_r, out_nxt;

  logic         advance;

  assign advance     = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      single_speed_r <= 1'b1;
    end else if (cfg_we) begin
      single_speed_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_r.op            <= in_ch.op;
      s1_r.timer_expired <= in_ch.timer_expired;
      s1_r.subcode_kind  <= in_ch.subcode_kind;
      s1_r.now.min       <= in_ch.now_min;
      s1_r.now.sec       <= in_ch.now_sec;
      s1_r.now.frm       <= in_ch.now_frm;
      s1_r.jump_status   <= in_ch.jump_status;
      s1_r.target.min    <= in_ch.target_min;
      s1_r.target.sec    <= in_ch.target_sec;
      s1_r.target.frm    <= in_ch.target_frm;
    end
  end

  always_comb begin
    cdsr_time_t win_low;
    cdsr_time_t win_high;
    cdsr_time_t win;
    logic       ok;
    monitor_nxt = monitor_r;
    repair_nxt  = repair_r;
    ref_nxt     = ref_r;
    out_nxt     = '0;
    out_nxt.reload_value = single_speed_r ? TIMER_LOAD_SINGLE : TIMER_LOAD_DOUBLE;
    win_low  = msf_add(ref_r, 1'b0, WIN_LOW_FRM);
    win_high = msf_add(ref_r, WIN_HIGH_SEC, 7'd0);
    // packed min/sec/frm compares in time order
    ok = (s1_r.now > win_low) && (win_high >= s1_r.now);
    win = '0;
    case (s1_r.op)
      OP_ENABLE: begin
        out_nxt.timer_reload = 1'b1;
        ref_nxt     = s1_r.target;
        monitor_nxt = 1'b1;
        repair_nxt  = 1'b0;
      end
      OP_DISABLE: begin
        monitor_nxt = 1'b0;
      end
      OP_POLL: begin
        if (monitor_r) begin
          if (!repair_r && s1_r.timer_expired) begin
            if (s1_r.subcode_kind == KIND_ABS) begin
              if (ok) begin
                out_nxt.timer_reload = 1'b1;
                ref_nxt = s1_r.now;
              end else begin
                repair_nxt = 1'b1;
                out_nxt.mute_set = 1'b1;
              end
            end else if (s1_r.subcode_kind == KIND_LEAD_IN) begin
              repair_nxt = 1'b1;
              out_nxt.mute_set = 1'b1;
            end
          end
          // in repair the reference holds unless the jump is ready (current time) or fails (jump target)
          if (repair_nxt) begin
            win = msf_add(ref_r, 1'b0, JUMP_AHEAD_FRM);
            out_nxt.jump_request = 1'b1;
            out_nxt.jump = win;
            if (s1_r.jump_status == JST_READY) begin
              repair_nxt = 1'b0;
              out_nxt.timer_reload = 1'b1;
              ref_nxt = s1_r.now;
              out_nxt.mute_clear = 1'b1;
            end else if (s1_r.jump_status == JST_ERROR) begin
              ref_nxt = win;
            end
          end
        end
      end
      default: begin
      end
    endcase
    out_nxt.active    = monitor_nxt;
    out_nxt.repairing = repair_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      monitor_r   <= 1'b0;
      repair_r    <= 1'b0;
      ref_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (advance) begin
        monitor_r <= monitor_nxt;
        repair_r  <= repair_nxt;
        ref_r     <= ref_nxt;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_r <= out_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.mute_set     = out_r.mute_set;
  assign out_ch.mute_clear   = out_r.mute_clear;
  assign out_ch.jump_request = out_r.jump_request;
  assign out_ch.jump_min     = out_r.jump.min;
  assign out_ch.jump_sec     = out_r.jump.sec;
  assign out_ch.jump_frm     = out_r.jump.frm;
  assign out_ch.timer_reload = out_r.timer_reload;
  assign out_ch.reload_value = out_r.reload_value;
  assign out_ch.active       = out_r.active;
  assign out_ch.repairing    = out_r.repairing;

endmodule

[hdl/cdsr_checker.sv]
// cdsr_checker: port-level assertions for the shock recovery monitor, bound to the top level
module cdsr_checker
  import cdsr_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic       mute_set,
  input logic       mute_clear,
  input logic       jump_request,
  input logic [6:0] jump_min,
  input logic [5:0] jump_sec,
  input logic [6:0] jump_frm,
  input logic       timer_reload,
  input logic [7:0] reload_value,
  input logic       repairing
);

  // a stalled result keeps its jump target and load value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid &&
      $stable({jump_request, jump_min, jump_sec, jump_frm, reload_value}))
    else $error("stalled result changed");

  // entering repair always issues the jump in the same step
  a_mute_jump: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && mute_set |-> jump_request)
    else $error("mute set without jump request");

  a_clear_reload: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && mute_clear |-> jump_request && timer_reload && !repairing)
    else $error("mute clear without completed jump");

  a_jump_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !jump_request |-> jump_min == 7'd0 && jump_sec == 6'd0 && jump_frm == 7'd0)
    else $error("jump target without request");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind cd_shock_recovery_monitor cdsr_checker u_cdsr_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .mute_set     (out_ch.mute_set),
  .mute_clear   (out_ch.mute_clear),
  .jump_request (out_ch.jump_request),
  .jump_min     (out_ch.jump_min),
  .jump_sec     (out_ch.jump_sec),
  .jump_frm     (out_ch.jump_frm),
  .timer_reload (out_ch.timer_reload),
  .reload_value (out_ch.reload_value),
  .repairing    (out_ch.repairing)
);

[sim/tb_top.sv]
// tb_top: self-checking bench for the shock recovery monitor with a shadow model of its steps
module tb_top
  import cdsr_pkg::*;
();

  // encodings the block must treat as no action
  localparam logic [1:0] OP_SPARE   = 2'd3;
  localparam logic [1:0] KIND_SPARE = 2'd3;
  localparam logic [1:0] JST_SPARE  = 2'd3;

  localparam int RUN_LIMIT    = 400000;
  localparam int PHASE_ITEMS  = 550;
  localparam int SETTLE_TICKS = 6;
  localparam int DISC_FRAMES  = 100 * 60 * 75;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;

  cdsr_in_if  in_ch();
  cdsr_out_if out_ch();

  cd_shock_recovery_monitor DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // shadow copy of the monitor state
  logic       speed_single;
  logic       mon_on;
  logic       in_repair;
  cdsr_time_t ref_time;

  cdsr_item_t   request_q[$];
  cdsr_result_t outcome_q[$];

  int n_queued;
  int n_accepted;
  int n_results;
  int mismatches;
  int n_repairs;
  int n_jumps;
  int n_reloads;
  int cycle_cnt;
  int send_idle_pct;
  int recv_idle_pct;

  // generator view of where the head is on the disc
  cdsr_time_t play_pos;
  int         frames_since;

  function automatic cdsr_time_t msf(int m, int s, int f);
    cdsr_time_t t;
    t.min = m[6:0];
    t.sec = s[5:0];
    t.frm = f[6:0];
    return t;
  endfunction

  // one carry per stage, then masked to the field widths
  function automatic cdsr_time_t time_plus(cdsr_time_t t, int add_sec, int add_frm);
    int f;
    int s;
    int m;
    f = int'(t.frm) + add_frm;
    s = int'(t.sec) + add_sec;
    m = int'(t.min);
    if (f >= 75) begin
      f -= 75;
      s++;
    end
    if (s >= 60) begin
      s -= 60;
      m++;
    end
    if (m >= 100) m -= 100;
    return msf(m, s, f);
  endfunction

  function automatic cdsr_result_t monitor_step(cdsr_item_t it);
    cdsr_result_t r;
    cdsr_time_t   base;
    cdsr_time_t   ahead;
    r = '0;
    r.reload_value = speed_single ? TIMER_LOAD_SINGLE : TIMER_LOAD_DOUBLE;
    base = ref_time;
    if (it.op == OP_ENABLE) begin
      r.timer_reload = 1'b1;
      ref_time = it.target;
      mon_on = 1'b1;
      in_repair = 1'b0;
    end else if (it.op == OP_DISABLE) begin
      mon_on = 1'b0;
    end else if (it.op == OP_POLL && mon_on) begin
      if (!in_repair && it.timer_expired) begin
        if (it.subcode_kind == KIND_ABS) begin
          // packed compare orders minutes, seconds, frames
          if (it.now > time_plus(base, 0, 15) && time_plus(base, 1, 0) >= it.now) begin
            r.timer_reload = 1'b1;
            base = it.now;
          end else begin
            in_repair = 1'b1;
            r.mute_set = 1'b1;
          end
        end else if (it.subcode_kind == KIND_LEAD_IN) begin
          in_repair = 1'b1;
          r.mute_set = 1'b1;
        end
      end
      if (in_repair) begin
        ahead = time_plus(base, 0, 40);
        r.jump_request = 1'b1;
        r.jump = ahead;
        if (it.jump_status == JST_READY) begin
          in_repair = 1'b0;
          r.timer_reload = 1'b1;
          r.mute_clear = 1'b1;
          base = it.now;
        end else if (it.jump_status == JST_ERROR) begin
          base = ahead;
        end
      end
      ref_time = base;
    end
    r.active = mon_on;
    r.repairing = in_repair;
    return r;
  endfunction

  function automatic cdsr_item_t req(logic [1:0] op, logic expired, logic [1:0] kind,
                                     cdsr_time_t now, logic [1:0] jst, cdsr_time_t tgt);
    cdsr_item_t it;
    it.op = op;
    it.timer_expired = expired;
    it.subcode_kind = kind;
    it.now = now;
    it.jump_status = jst;
    it.target = tgt;
    return it;
  endfunction

  function automatic cdsr_time_t legal_time();
    return msf($urandom_range(99), $urandom_range(59), $urandom_range(74));
  endfunction

  function automatic cdsr_time_t frames_later(cdsr_time_t t, int n);
    int tot;
    tot = (int'(t.min) * 60 + int'(t.sec)) * 75 + int'(t.frm) + n;
    tot = tot % DISC_FRAMES;
    if (tot < 0) tot += DISC_FRAMES;
    return msf(tot / 4500, (tot / 75) % 60, tot % 75);
  endfunction

  function automatic logic [1:0] pick_status();
    int p;
    p = $urandom_range(99);
    if (p < 50) return JST_READY;
    if (p < 70) return JST_ERROR;
    if (p < 95) return JST_BUSY;
    return JST_SPARE;
  endfunction

  // mostly a playing disc with plausible time steps, some shocks, some noise
  function automatic cdsr_item_t play_request();
    cdsr_item_t it;
    int pick;
    int adv;
    int k;
    pick = $urandom_range(99);
    it = req(OP_POLL, 1'b0, KIND_ABS, play_pos, pick_status(), legal_time());
    if (pick < 4) begin
      it.op = OP_ENABLE;
      it.target = play_pos;
      frames_since = 0;
    end else if (pick < 6) begin
      it.op = OP_DISABLE;
    end else if (pick < 8) begin
      it.op = OP_SPARE;
    end else if (pick < 20) begin
      it.op = 2'($urandom_range(3));
      it.timer_expired = 1'($urandom);
      it.subcode_kind = 2'($urandom_range(3));
      it.now = 20'($urandom);
      it.jump_status = 2'($urandom_range(3));
      it.target = 20'($urandom);
    end else begin
      if ($urandom_range(29) == 0) play_pos = legal_time();
      adv = $urandom_range(8);
      play_pos = frames_later(play_pos, adv);
      frames_since += adv;
      if (frames_since >= 16) it.timer_expired = ($urandom_range(3) != 0);
      else it.timer_expired = ($urandom_range(9) == 0);
      if (it.timer_expired) frames_since = 0;
      k = $urandom_range(99);
      if (k < 85) it.subcode_kind = KIND_ABS;
      else if (k < 92) it.subcode_kind = KIND_LEAD_IN;
      else if (k < 97) it.subcode_kind = KIND_OTHER;
      else it.subcode_kind = KIND_SPARE;
      it.now = play_pos;
    end
    return it;
  endfunction

  task automatic queue_req(cdsr_item_t it);
    request_q.push_back(it);
    n_queued++;
  endtask

  task automatic drain();
    while (n_accepted != n_queued || outcome_q.size() != 0) @(posedge clk);
  endtask

  task automatic set_speed(logic v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    speed_single = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic play_phase(int count);
    queue_req(req(OP_ENABLE, 1'b0, KIND_ABS, play_pos, JST_BUSY, play_pos));
    frames_since = 0;
    repeat (count - 1) queue_req(play_request());
  endtask

  task automatic check_field(string name, int want_v, int got_v);
    if (want_v != got_v) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch in %s of result %0d: expected %0d, got %0d",
                 name, n_results, want_v, got_v);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == RUN_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_cnt, outcome_q.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // request driver
  always @(posedge clk) begin : drive_requests
    cdsr_item_t nxt;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (request_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = request_q.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.op <= nxt.op;
        in_ch.timer_expired <= nxt.timer_expired;
        in_ch.subcode_kind <= nxt.subcode_kind;
        in_ch.now_min <= nxt.now.min;
        in_ch.now_sec <= nxt.now.sec;
        in_ch.now_frm <= nxt.now.frm;
        in_ch.jump_status <= nxt.jump_status;
        in_ch.target_min <= nxt.target.min;
        in_ch.target_sec <= nxt.target.sec;
        in_ch.target_frm <= nxt.target.frm;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // result checker, then prediction for the request taken at this edge
  always @(posedge clk) begin : watch_results
    cdsr_item_t   taken;
    cdsr_result_t got;
    cdsr_result_t want;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got.mute_set = out_ch.mute_set;
        got.mute_clear = out_ch.mute_clear;
        got.jump_request = out_ch.jump_request;
        got.jump = msf(out_ch.jump_min, out_ch.jump_sec, out_ch.jump_frm);
        got.timer_reload = out_ch.timer_reload;
        got.reload_value = out_ch.reload_value;
        got.active = out_ch.active;
        got.repairing = out_ch.repairing;
        if (outcome_q.size() == 0) begin
          check_field("result with nothing outstanding", 0, 1);
        end else begin
          want = outcome_q.pop_front();
          check_field("mute_set", want.mute_set, got.mute_set);
          check_field("mute_clear", want.mute_clear, got.mute_clear);
          check_field("jump_request", want.jump_request, got.jump_request);
          check_field("jump_min", want.jump.min, got.jump.min);
          check_field("jump_sec", want.jump.sec, got.jump.sec);
          check_field("jump_frm", want.jump.frm, got.jump.frm);
          check_field("timer_reload", want.timer_reload, got.timer_reload);
          check_field("reload_value", want.reload_value, got.reload_value);
          check_field("active", want.active, got.active);
          check_field("repairing", want.repairing, got.repairing);
        end
        n_results++;
      end
      if (in_ch.valid && in_ch.ready) begin
        taken.op = in_ch.op;
        taken.timer_expired = in_ch.timer_expired;
        taken.subcode_kind = in_ch.subcode_kind;
        taken.now = msf(in_ch.now_min, in_ch.now_sec, in_ch.now_frm);
        taken.jump_status = in_ch.jump_status;
        taken.target = msf(in_ch.target_min, in_ch.target_sec, in_ch.target_frm);
        want = monitor_step(taken);
        if (want.mute_set) n_repairs++;
        if (want.jump_request) n_jumps++;
        if (want.timer_reload) n_reloads++;
        outcome_q.push_back(want);
        n_accepted++;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.op = OP_POLL;
    in_ch.timer_expired = 1'b0;
    in_ch.subcode_kind = KIND_OTHER;
    in_ch.now_min = '0;
    in_ch.now_sec = '0;
    in_ch.now_frm = '0;
    in_ch.jump_status = JST_READY;
    in_ch.target_min = '0;
    in_ch.target_sec = '0;
    in_ch.target_frm = '0;
    out_ch.ready = 1'b0;
    speed_single = 1'b1;
    mon_on = 1'b0;
    in_repair = 1'b0;
    ref_time = '0;
    play_pos = msf(2, 0, 0);
    frames_since = 0;
    send_idle_pct = 37;
    recv_idle_pct = 79;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed walk through the window edges and the repair outcomes
    queue_req(req(OP_POLL, 1'b1, KIND_ABS, msf(0, 0, 20), JST_READY, msf(0, 0, 0)));
    queue_req(req(OP_ENABLE, 1'b0, KIND_OTHER, msf(0, 0, 0), JST_BUSY, msf(0, 0, 0)));
    queue_req(req(OP_POLL, 1'b1, KIND_ABS, msf(0, 0, 16), JST_READY, msf(0, 0, 0)));
    // exactly 15 frames ahead is too slow
    queue_req(req(OP_POLL, 1'b1, KIND_ABS, msf(0, 0, 31), JST_BUSY, msf(0, 0, 0)));
    queue_req(req(OP_POLL, 1'b0, KIND_ABS, msf(0, 0, 31), JST_ERROR, msf(0, 0, 0)));
    queue_req(req(OP_POLL, 1'b1, KIND_ABS, msf(0, 0, 40), JST_SPARE, msf(0, 0, 0)));
    queue_req(req(OP_POLL, 1'b1, KIND_ABS, msf(0, 1, 21), JST_READY, msf(0, 0, 0)));
    // exactly one second ahead still passes, one frame more does not
    queue_req(req(OP_POLL, 1'b1, KIND_ABS, msf(0, 2, 21), JST_BUSY, msf(0, 0, 0)));
    queue_req(req(OP_POLL, 1'b1, KIND_ABS, msf(0, 3, 22), JST_READY, msf(0, 0, 0)));
    queue_req(req(OP_POLL, 1'b1, KIND_LEAD_IN, msf(0, 3, 40), JST_BUSY, msf(0, 0, 0)));
    queue_req(req(OP_DISABLE, 1'b1, KIND_ABS, msf(0, 3, 50), JST_READY, msf(0, 0, 0)));
    queue_req(req(OP_POLL, 1'b1, KIND_LEAD_IN, msf(0, 3, 60), JST_READY, msf(0, 0, 0)));
    queue_req(req(OP_ENABLE, 1'b1, KIND_ABS, msf(0, 0, 0), JST_ERROR, msf(99, 59, 74)));
    // window wraps past 99:59:74
    queue_req(req(OP_POLL, 1'b1, KIND_ABS, msf(0, 0, 30), JST_ERROR, msf(0, 0, 0)));
    queue_req(req(OP_POLL, 1'b1, KIND_OTHER, msf(50, 0, 0), JST_READY, msf(0, 0, 0)));
    queue_req(req(OP_POLL, 1'b1, KIND_SPARE, msf(50, 0, 0), JST_READY, msf(0, 0, 0)));
    queue_req(req(OP_POLL, 1'b0, KIND_ABS, msf(50, 0, 0), JST_READY, msf(0, 0, 0)));
    queue_req(req(OP_SPARE, 1'b1, KIND_LEAD_IN, msf(0, 0, 0), JST_READY, msf(1, 1, 1)));
    queue_req(req(OP_ENABLE, 1'b0, KIND_ABS, msf(0, 0, 0), JST_READY, msf(127, 63, 127)));
    queue_req(req(OP_POLL, 1'b1, KIND_ABS, msf(127, 63, 127), JST_ERROR, msf(0, 0, 0)));
    queue_req(req(OP_POLL, 1'b1, KIND_ABS, msf(127, 63, 127), JST_BUSY, msf(0, 0, 0)));
    queue_req(req(OP_POLL, 1'b0, KIND_OTHER, msf(0, 0, 0), JST_READY, msf(0, 0, 0)));
    queue_req(req(OP_ENABLE, 1'b0, KIND_ABS, msf(0, 0, 0), JST_READY, msf(0, 0, 0)));

    set_speed(1'b0);
    play_phase(PHASE_ITEMS);

    send_idle_pct = 79;
    recv_idle_pct = 37;
    set_speed(1'b1);
    play_phase(PHASE_ITEMS);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_speed(1'b0);
    play_phase(PHASE_ITEMS);

    drain();
    repeat (SETTLE_TICKS) @(posedge clk);
    $display("%0d requests checked under three stall patterns with both timer speeds",
             n_accepted);
    $display("%0d repairs entered, %0d jumps, %0d timer reloads, %0d mismatches",
             n_repairs, n_jumps, n_reloads, mismatches);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
